[hw/rtl/tpb_pkg.sv]
// ----------------------------------------------------------------------------
// Temporal pixel blend package
// Shared widths, fixed-point constants and pipeline geometry.
// ----------------------------------------------------------------------------
`default_nettype none

package tpb_pkg;

    // Pipeline geometry: stage 0 takes the transfer, the last stage is the output
    localparam int unsigned STAGES    = 10;
    localparam int unsigned ALPHA_STG = 7;   // stage whose register holds alpha

    typedef logic [7:0]        t_pix;
    typedef logic [8:0]        t_q8;     // Q8 fraction, 256 = 1.0
    typedef logic [16:0]       t_q16;    // Q16 fraction, 65536 = 1.0 inclusive
    typedef logic [15:0]       t_mix;    // Q16 fraction strictly below 1.0
    typedef logic [STAGES-1:0] t_stg_en; // per-stage load enables

    typedef enum logic [2:0] {
        REG_BLEND = 3'd0,
        REG_SMEAR = 3'd1,
        REG_BLEED = 3'd2,
        REG_LUMA  = 3'd3
    } t_cfg_idx;

    localparam t_q8   Q8_ONE    = 9'd256;
    localparam t_q16  Q16_ONE   = 17'd65536;
    localparam t_mix  BLEED_K   = 16'd36045;  // 0.55
    localparam t_mix  SMEAR_K   = 16'd22938;  // 0.35
    localparam t_mix  LUMA_K    = 16'd42598;  // 0.65
    localparam logic [9:0]  LUMA_DIV  = 10'd765;
    localparam logic [10:0] LUMA_DIV2 = 11'd1530;
    localparam logic [8:0]  LUMA_RND  = 9'd382;
    localparam logic [22:0] RECIP_K   = 23'd5614336; // floor(2^32 / 765)
    localparam t_pix  PIX_MAX   = 8'd255;

endpackage

`default_nettype wire

[hw/rtl/tpb_alpha.sv]
// ----------------------------------------------------------------------------
// Temporal pixel blend alpha unit
// Previous pixel luma and the blend alpha, one pixel per cycle when enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module tpb_alpha (
    input  wire logic            i_clk,
    input  wire tpb_pkg::t_stg_en i_en,
    input  wire tpb_pkg::t_pix   i_prev_red,
    input  wire tpb_pkg::t_pix   i_prev_green,
    input  wire tpb_pkg::t_pix   i_prev_blue,
    input  wire tpb_pkg::t_mix   i_lsc,
    input  wire tpb_pkg::t_q16   i_a0,
    output tpb_pkg::t_q16        o_alpha
);
    import tpb_pkg::*;

    logic [9:0]  r_sum;
    logic [9:0]  r_sum1;
    logic [32:0] r_p;
    logic [16:0] r_qe;
    logic [11:0] r_rem;
    t_q16        r_luma;
    logic [32:0] r_lg;
    t_q16        r_gain;
    logic [33:0] r_ag;
    t_q16        r_alpha;

    logic [16:0] w_qe;
    logic [25:0] w_x;
    logic [25:0] w_qm;
    logic [25:0] w_rem;
    logic [1:0]  w_corr;
    logic [33:0] w_lr;
    logic [33:0] w_ar;

    // Luma by reciprocal estimate, then a remainder correction of up to two
    assign w_qe  = r_p[32:16];
    assign w_x   = {r_sum1, 16'd0} + 26'(LUMA_RND);
    assign w_qm  = 26'(w_qe) * 26'(LUMA_DIV);
    assign w_rem = w_x - w_qm;

    always_comb begin
        if (r_rem >= 12'(LUMA_DIV2)) begin
            w_corr = 2'd2;
        end else if (r_rem >= 12'(LUMA_DIV)) begin
            w_corr = 2'd1;
        end else begin
            w_corr = 2'd0;
        end
    end

    assign w_lr = 34'(r_lg) + 34'd32768;
    assign w_ar = r_ag + 34'd32768;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_sum <= 10'(i_prev_red) + 10'(i_prev_green) + 10'(i_prev_blue);
        end
        if (i_en[1]) begin
            r_p    <= 33'(r_sum) * 33'(RECIP_K);
            r_sum1 <= r_sum;
        end
        if (i_en[2]) begin
            r_qe  <= w_qe;
            r_rem <= w_rem[11:0];
        end
        if (i_en[3]) begin
            r_luma <= r_qe + 17'(w_corr);
        end
        if (i_en[4]) begin
            r_lg <= 33'(r_luma) * 33'(i_lsc);
        end
        if (i_en[5]) begin
            r_gain <= Q16_ONE + 17'(w_lr[31:16]);
        end
        if (i_en[6]) begin
            r_ag <= 34'(i_a0) * 34'(r_gain);
        end
        if (i_en[ALPHA_STG]) begin
            r_alpha <= (w_ar[33:16] > 18'(Q16_ONE)) ? Q16_ONE : w_ar[32:16];
        end
    end

    assign o_alpha = r_alpha;

endmodule

`default_nettype wire

[hw/rtl/tpb_lane.sv]
// ----------------------------------------------------------------------------
// Temporal pixel blend colour lane
// Bleed target and final mix for one colour channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tpb_lane (
    input  wire logic             i_clk,
    input  wire tpb_pkg::t_stg_en i_en,
    input  wire tpb_pkg::t_pix    i_cur,
    input  wire tpb_pkg::t_pix    i_prev,
    input  wire tpb_pkg::t_pix    i_next,
    input  wire tpb_pkg::t_mix    i_bmix,
    input  wire tpb_pkg::t_q16    i_keep,
    input  wire tpb_pkg::t_q16    i_alpha,
    output tpb_pkg::t_pix         o_pix
);
    import tpb_pkg::*;

    t_pix        r_cur [0:ALPHA_STG];
    logic [23:0] r_tgt [2:ALPHA_STG];
    t_pix        r_prv;
    t_pix        r_nxt;
    logic [23:0] r_tk;
    logic [23:0] r_tn;
    logic [24:0] r_m1;
    logic [40:0] r_m2;
    t_pix        r_out;

    logic [41:0] w_acc;
    logic [9:0]  w_val;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_cur[0] <= i_cur;
            r_prv    <= i_prev;
            r_nxt    <= i_next;
        end
        if (i_en[1]) begin
            r_cur[1] <= r_cur[0];
            r_tk     <= 24'(r_prv) * 24'(i_keep);
            r_tn     <= 24'(r_nxt) * 24'(i_bmix);
        end
        if (i_en[2]) begin
            r_cur[2] <= r_cur[1];
            r_tgt[2] <= r_tk + r_tn;
        end
        // Delay the current byte and the target until alpha is ready
        for (int k = 3; k <= ALPHA_STG; k++) begin
            if (i_en[k]) begin
                r_cur[k] <= r_cur[k-1];
                r_tgt[k] <= r_tgt[k-1];
            end
        end
    end

    assign w_acc = 42'({r_m1, 16'd0}) + 42'(r_m2);
    assign w_val = w_acc[41:32];

    always_ff @(posedge i_clk) begin
        if (i_en[ALPHA_STG+1]) begin
            r_m1 <= 25'(r_cur[ALPHA_STG]) * 25'(Q16_ONE - i_alpha);
            r_m2 <= 41'(r_tgt[ALPHA_STG]) * 41'(i_alpha);
        end
        if (i_en[ALPHA_STG+2]) begin
            r_out <= (w_val > 10'(PIX_MAX)) ? PIX_MAX : w_val[7:0];
        end
    end

    assign o_pix = r_out;

endmodule

`default_nettype wire

[hw/rtl/temporal_pixel_blend.sv]
// ----------------------------------------------------------------------------
// Temporal pixel blend
// Blends each current pixel toward the bled previous pixel by a luma-scaled alpha.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle while the output takes results, set by the
// ten-stage pipeline of the alpha unit and the three colour lanes; any stage
// that is empty takes data even while the output register holds a result.
// Reset: synchronous, active low; clears all stage valids and sets every
// strength to zero, so the block passes the current pixel through.
`default_nettype none

module temporal_pixel_blend (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // pixel input
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire tpb_pkg::t_pix i_cur_red,
    input  wire tpb_pkg::t_pix i_cur_green,
    input  wire tpb_pkg::t_pix i_cur_blue,
    input  wire tpb_pkg::t_pix i_prev_red,
    input  wire tpb_pkg::t_pix i_prev_green,
    input  wire tpb_pkg::t_pix i_prev_blue,
    // pixel output
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output tpb_pkg::t_pix      o_out_red,
    output tpb_pkg::t_pix      o_out_green,
    output tpb_pkg::t_pix      o_out_blue,
    // configuration writes
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_idx,
    input  wire tpb_pkg::t_q8  i_cfg_data
);
    import tpb_pkg::*;

    // ---------------------------------------------------------------------
    // Strength registers. Values are clamped to 1.0 on the way in, and the
    // derived Q16 factors are worked out at write time so that the pixel
    // path sees constants only.
    // ---------------------------------------------------------------------
    t_q8  r_blend;
    t_q16 r_sfac;
    t_mix r_bmix;
    t_q16 r_keep;
    t_mix r_lsc;
    t_q16 r_a0;

    t_q8         w_cfg_v;
    logic [24:0] w_bleed_p;
    logic [24:0] w_smear_p;
    logic [24:0] w_luma_p;
    logic [24:0] w_a0_p;
    t_mix        n_bmix;

    assign w_cfg_v   = (i_cfg_data > Q8_ONE) ? Q8_ONE : i_cfg_data;
    assign w_bleed_p = 25'(w_cfg_v) * 25'(BLEED_K) + 25'd128;
    assign w_smear_p = 25'(w_cfg_v) * 25'(SMEAR_K) + 25'd128;
    assign w_luma_p  = 25'(w_cfg_v) * 25'(LUMA_K) + 25'd128;
    assign n_bmix    = w_bleed_p[23:8];
    assign w_a0_p    = 25'(r_blend) * 25'(r_sfac) + 25'd128;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend <= '0;
            r_sfac  <= Q16_ONE;
            r_bmix  <= '0;
            r_keep  <= Q16_ONE;
            r_lsc   <= '0;
            r_a0    <= '0;
        end else begin
            // a0 takes a blend or smear write in the cycle after the write; it is first
            // used by the alpha unit where it multiplies the luma gain
            r_a0 <= w_a0_p[24:8];
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_BLEND: begin
                        r_blend <= w_cfg_v;
                    end
                    REG_SMEAR: begin
                        r_sfac <= Q16_ONE - 17'(w_smear_p[23:8]);
                    end
                    REG_BLEED: begin
                        r_bmix <= n_bmix;
                        r_keep <= Q16_ONE - 17'(n_bmix);
                    end
                    REG_LUMA: begin
                        r_lsc <= w_luma_p[23:8];
                    end
                    default: begin
                        // drop writes beyond the register list
                    end
                endcase
            end
        end
    end

    // ---------------------------------------------------------------------
    // Pipeline control: each stage loads when it is empty or when the stage
    // after it loads, so bubbles collapse; while a result waits in the output
    // register the input keeps taking pixels as long as any stage is empty.
    // ---------------------------------------------------------------------
    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] n_vld;
    t_stg_en           w_en;

    always_comb begin
        w_en[STAGES-1] = !r_vld[STAGES-1] || i_out_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_comb begin
        for (int k = 0; k < STAGES; k++) begin
            if (w_en[k]) begin
                n_vld[k] = (k == 0) ? i_in_valid : r_vld[(k == 0) ? 0 : k - 1];
            end else begin
                n_vld[k] = r_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_vld[STAGES-1];

    // ---------------------------------------------------------------------
    // Shared alpha unit and three colour lanes. Bleed rotates the previous
    // pixel: red takes from green, green from blue, blue from red. The lane
    // output registers form the merged result register.
    // ---------------------------------------------------------------------
    t_q16 w_alpha;

    tpb_alpha u_alpha (
        .i_clk        (i_clk),
        .i_en         (w_en),
        .i_prev_red   (i_prev_red),
        .i_prev_green (i_prev_green),
        .i_prev_blue  (i_prev_blue),
        .i_lsc        (r_lsc),
        .i_a0         (r_a0),
        .o_alpha      (w_alpha)
    );

    tpb_lane u_lane_red (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_cur   (i_cur_red),
        .i_prev  (i_prev_red),
        .i_next  (i_prev_green),
        .i_bmix  (r_bmix),
        .i_keep  (r_keep),
        .i_alpha (w_alpha),
        .o_pix   (o_out_red)
    );

    tpb_lane u_lane_green (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_cur   (i_cur_green),
        .i_prev  (i_prev_green),
        .i_next  (i_prev_blue),
        .i_bmix  (r_bmix),
        .i_keep  (r_keep),
        .i_alpha (w_alpha),
        .o_pix   (o_out_green)
    );

    tpb_lane u_lane_blue (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_cur   (i_cur_blue),
        .i_prev  (i_prev_blue),
        .i_next  (i_prev_red),
        .i_bmix  (r_bmix),
        .i_keep  (r_keep),
        .i_alpha (w_alpha),
        .o_pix   (o_out_blue)
    );

endmodule

`default_nettype wire

[hw/rtl/tpb_checker.sv]
// ----------------------------------------------------------------------------
// Temporal pixel blend port checker
// Watches the top-level handshakes over time.
// ----------------------------------------------------------------------------
`default_nettype none

module tpb_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input wire logic          o_in_ready,
    input wire logic          o_out_valid,
    input wire logic          i_out_ready,
    input wire tpb_pkg::t_pix o_out_red,
    input wire tpb_pkg::t_pix o_out_green,
    input wire tpb_pkg::t_pix o_out_blue
);

    // Reset empties the output register
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // An empty or draining output frees the whole pipeline
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) |-> o_in_ready)
        else $error("input stalled while output can move");

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result withdrawn before transfer");

    // A stalled result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            ($stable(o_out_red) && $stable(o_out_green) && $stable(o_out_blue)))
        else $error("result changed while stalled");

endmodule

bind temporal_pixel_blend tpb_checker u_tpb_checker (.*);

`default_nettype wire

[sim/tb_temporal_pixel_blend.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Temporal pixel blend testbench
// Streams pixels through the blend pipeline under several strength settings
// and idling patterns. Each accepted pixel is blended in software and the
// block's output is checked channel by channel, in order.
// ----------------------------------------------------------------------------

module tb_temporal_pixel_blend;

    import tpb_pkg::t_pix;
    import tpb_pkg::t_q8;
    import tpb_pkg::REG_BLEND;
    import tpb_pkg::REG_SMEAR;
    import tpb_pkg::REG_BLEED;
    import tpb_pkg::REG_LUMA;

    // Constants of the blend arithmetic; ONE_Q16 and the mix factors are Q16
    localparam logic [63:0] ONE_Q16      = 64'd65536;
    localparam logic [63:0] ONE_Q8       = 64'd256;
    localparam logic [63:0] MIX_BLEED    = 64'd36045;  // 0.55
    localparam logic [63:0] MIX_SMEAR    = 64'd22938;  // 0.35
    localparam logic [63:0] MIX_LUMA     = 64'd42598;  // 0.65
    localparam logic [63:0] LUMA_DIVISOR = 64'd765;    // three full-scale channels
    localparam logic [63:0] LUMA_HALF    = 64'd382;
    localparam logic [63:0] CHAN_MAX     = 64'd255;

    localparam logic [2:0]  REG_SPARE_LO = 3'd4;       // first index with no register
    localparam int          PIPE_LATENCY = 10;
    localparam int          PHASE_PIXELS = 128;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          PRINT_LIMIT  = 40;

    typedef struct packed {
        t_pix cur_red;
        t_pix cur_green;
        t_pix cur_blue;
        t_pix prev_red;
        t_pix prev_green;
        t_pix prev_blue;
    } t_pixel;

    typedef struct packed {
        t_pix red;
        t_pix green;
        t_pix blue;
    } t_rgb;

    // Block inputs, all known from time zero
    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_in_valid   = 1'b0;
    t_pix       i_cur_red    = '0;
    t_pix       i_cur_green  = '0;
    t_pix       i_cur_blue   = '0;
    t_pix       i_prev_red   = '0;
    t_pix       i_prev_green = '0;
    t_pix       i_prev_blue  = '0;
    logic       i_out_ready  = 1'b0;
    logic       i_cfg_we     = 1'b0;
    logic [2:0] i_cfg_idx    = '0;
    t_q8        i_cfg_data   = '0;

    logic       o_in_ready;
    logic       o_out_valid;
    t_pix       o_out_red;
    t_pix       o_out_green;
    t_pix       o_out_blue;

    // Software copy of the strength registers
    t_q8 cfg_blend = '0;
    t_q8 cfg_smear = '0;
    t_q8 cfg_bleed = '0;
    t_q8 cfg_luma  = '0;

    t_rgb pending_blends[$];

    int error_count      = 0;
    int pixels_sent      = 0;
    int blends_checked   = 0;
    int settings_applied = 0;
    int send_idle_pct    = 0;
    int stall_pct        = 0;
    int rx_hold_len      = 0;   // request for a long receiver hold-off
    int rx_hold_left     = 0;

    temporal_pixel_blend dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cur_red    (i_cur_red),
        .i_cur_green  (i_cur_green),
        .i_cur_blue   (i_cur_blue),
        .i_prev_red   (i_prev_red),
        .i_prev_green (i_prev_green),
        .i_prev_blue  (i_prev_blue),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_red    (o_out_red),
        .o_out_green  (o_out_green),
        .o_out_blue   (o_out_blue),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Blend predictor
    // ------------------------------------------------------------------------

    // Strengths above 1.0 saturate to 1.0
    function automatic logic [63:0] sat_q8(input t_q8 v);
        return (64'(v) > ONE_Q8) ? ONE_Q8 : 64'(v);
    endfunction

    function automatic t_rgb blend_pixel(input t_pixel px);
        logic [63:0] b, s, d, l;
        logic [63:0] bmix, sfac, lsc, luma, a0, gain, alpha, tgt, acc;
        logic [63:0] cur [3];
        logic [63:0] prv [3];
        logic [63:0] chan [3];
        t_rgb        res;
        cur[0] = 64'(px.cur_red);
        cur[1] = 64'(px.cur_green);
        cur[2] = 64'(px.cur_blue);
        prv[0] = 64'(px.prev_red);
        prv[1] = 64'(px.prev_green);
        prv[2] = 64'(px.prev_blue);
        b = sat_q8(cfg_blend);
        s = sat_q8(cfg_smear);
        d = sat_q8(cfg_bleed);
        l = sat_q8(cfg_luma);
        // Zero blend: the current pixel goes straight through
        if (b == 64'd0) begin
            res.red   = px.cur_red;
            res.green = px.cur_green;
            res.blue  = px.cur_blue;
            return res;
        end
        bmix  = (d * MIX_BLEED + 64'd128) >> 8;
        sfac  = ONE_Q16 - ((s * MIX_SMEAR + 64'd128) >> 8);
        lsc   = (l * MIX_LUMA + 64'd128) >> 8;
        luma  = ((prv[0] + prv[1] + prv[2]) * ONE_Q16 + LUMA_HALF) / LUMA_DIVISOR;
        a0    = (b * sfac + 64'd128) >> 8;
        gain  = ONE_Q16 + ((luma * lsc + 64'd32768) >> 16);
        alpha = (a0 * gain + 64'd32768) >> 16;
        if (alpha > ONE_Q16)
            alpha = ONE_Q16;
        // Bled target: each channel takes a share of the next, wrapping blue to red
        for (int k = 0; k < 3; k++) begin
            tgt     = prv[k] * (ONE_Q16 - bmix) + prv[(k + 1) % 3] * bmix;
            acc     = (((cur[k] * (ONE_Q16 - alpha)) << 16) + tgt * alpha) >> 32;
            chan[k] = (acc > CHAN_MAX) ? CHAN_MAX : acc;
        end
        res.red   = chan[0][7:0];
        res.green = chan[1][7:0];
        res.blue  = chan[2][7:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("MISMATCH at %0t: %s: got %0d, want %0d", $realtime, what, got, want);
    endtask

    // Compare every output transfer with the oldest predicted blend
    always @(posedge i_clk) begin : check_blk
        t_rgb want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_blends.size() == 0) begin
                report_mismatch("result with nothing pending", o_out_red, 0);
            end else begin
                want = pending_blends.pop_front();
                blends_checked++;
                if (o_out_red !== want.red)
                    report_mismatch("red", o_out_red, want.red);
                if (o_out_green !== want.green)
                    report_mismatch("green", o_out_green, want.green);
                if (o_out_blue !== want.blue)
                    report_mismatch("blue", o_out_blue, want.blue);
            end
        end
    end

    // Receiver: stall at random, or hold off for a counted stretch on request
    always @(posedge i_clk) begin
        if (rx_hold_len != 0) begin
            rx_hold_left = rx_hold_len;
            rx_hold_len  = 0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Abandon the run if it hangs
    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", pending_blends.size());
        $display("tb_temporal_pixel_blend: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers; all of them start and end on a rising edge
    // ------------------------------------------------------------------------

    function automatic t_pixel make_pixel(input t_pix cr, input t_pix cg, input t_pix cb,
                                          input t_pix pr, input t_pix pg, input t_pix pb);
        t_pixel px;
        px = '{cr, cg, cb, pr, pg, pb};
        return px;
    endfunction

    // Bias towards the channel extremes, otherwise uniform
    function automatic t_pix rand_chan();
        case ($urandom_range(7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return t_pix'($urandom_range(255));
        endcase
    endfunction

    function automatic t_pixel rand_pixel();
        return make_pixel(rand_chan(), rand_chan(), rand_chan(),
                          rand_chan(), rand_chan(), rand_chan());
    endfunction

    // Mix of zero, full scale, saturating and in-range strengths
    function automatic t_q8 rand_strength();
        case ($urandom_range(5))
            0:       return 9'd0;
            1:       return 9'd256;
            2:       return t_q8'($urandom_range(511));
            default: return t_q8'($urandom_range(256));
        endcase
    endfunction

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
    endtask

    // Offer one pixel; valid stays high after the transfer for the caller to drop
    task automatic send_pixel(input t_pixel px);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cur_red    <= px.cur_red;
        i_cur_green  <= px.cur_green;
        i_cur_blue   <= px.cur_blue;
        i_prev_red   <= px.prev_red;
        i_prev_green <= px.prev_green;
        i_prev_blue  <= px.prev_blue;
        do @(posedge i_clk); while (!o_in_ready);
        pending_blends.push_back(blend_pixel(px));
        pixels_sent++;
    endtask

    // Drop valid and wait for every predicted blend to come out
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_blends.size() != 0)
            @(posedge i_clk);
    endtask

    // Write enable stays high across back-to-back writes; finish_writes drops it
    task automatic write_reg(input logic [2:0] idx, input t_q8 val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_BLEND: cfg_blend = val;
            REG_SMEAR: cfg_smear = val;
            REG_BLEED: cfg_bleed = val;
            REG_LUMA:  cfg_luma  = val;
            default:   ;
        endcase
    endtask

    task automatic finish_writes();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_config(input t_q8 blend, input t_q8 smear,
                                input t_q8 bleed, input t_q8 luma);
        drain();
        write_reg(REG_BLEND, blend);
        write_reg(REG_SMEAR, smear);
        write_reg(REG_BLEED, bleed);
        write_reg(REG_LUMA,  luma);
        finish_writes();
        settings_applied++;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset strengths are zero, so every pixel passes through untouched
    task automatic test_passthrough();
        send_pixel(make_pixel(8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255));
        send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0));
        send_pixel(make_pixel(8'h5A,  8'hA5,  8'h0F,  8'hF0,  8'h3C,  8'hC3));
    endtask

    // Writes to indexes past the register list must leave the strengths alone
    task automatic test_spare_index();
        drain();
        for (int i = 0; i < 4; i++)
            write_reg(REG_SPARE_LO + 3'(i), 9'h1FF);
        finish_writes();
        send_pixel(make_pixel(8'd17, 8'd200, 8'd99, 8'd255, 8'd255, 8'd255));
        send_pixel(make_pixel(8'd255, 8'd0, 8'd128, 8'd0, 8'd255, 8'd64));
    endtask

    // Full blend with no bleed and no luma gain copies the previous pixel
    task automatic test_full_blend();
        apply_config(9'd256, 9'd0, 9'd0, 9'd0);
        send_pixel(make_pixel(8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255));
        send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0));
        send_pixel(make_pixel(8'd10,  8'd20,  8'd30,  8'd200, 8'd100, 8'd50));
        // Full bleed rotates most of each channel into its neighbour
        apply_config(9'd256, 9'd0, 9'd256, 9'd0);
        send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0));
        send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd128));
    endtask

    // Strengths above 1.0 behave as exactly 1.0
    task automatic test_clamped_registers();
        apply_config(9'd511, 9'd511, 9'd511, 9'd511);
        send_pixel(make_pixel(8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255));
        send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0));
        send_pixel(make_pixel(8'd77,  8'd150, 8'd3,   8'd180, 8'd40,  8'd220));
        apply_config(9'd257, 9'd300, 9'd384, 9'd400);
        send_pixel(make_pixel(8'd200, 8'd60, 8'd90, 8'd30, 8'd240, 8'd130));
    endtask

    // Tiny alpha, full smear, and the luma gain pushing alpha into its cap
    task automatic test_alpha_extremes();
        apply_config(9'd1, 9'd0, 9'd0, 9'd0);
        send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0));
        send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255));
        apply_config(9'd256, 9'd0, 9'd0, 9'd256);
        send_pixel(make_pixel(8'd0, 8'd128, 8'd255, 8'd255, 8'd255, 8'd255));
        send_pixel(make_pixel(8'd255, 8'd0, 8'd40, 8'd1, 8'd0, 8'd0));
        apply_config(9'd200, 9'd256, 9'd128, 9'd256);
        send_pixel(make_pixel(8'd255, 8'd255, 8'd0, 8'd255, 8'd128, 8'd0));
        send_pixel(make_pixel(8'd13, 8'd250, 8'd99, 8'd200, 8'd255, 8'd180));
    endtask

    // Hold the output back long enough for the pipeline to fill and push back
    // on the input, keep offering pixels, then pause until all are out
    task automatic test_output_hold();
        apply_config(9'd180, 9'd90, 9'd200, 9'd150);
        set_idling(0, 0);
        rx_hold_len = HOLD_CYCLES;
        for (int i = 0; i < 60; i++)
            send_pixel(rand_pixel());
        drain();
    endtask

    // One random phase: a register setting, an idling pattern, random pixels
    task automatic test_random_phase(input int phase);
        case (phase)
            0:       apply_config(9'd256, 9'd0,   9'd0,   9'd256);
            1:       apply_config(9'd256, 9'd256, 9'd256, 9'd256);
            2:       apply_config(9'd511, 9'd511, 9'd511, 9'd511);
            3:       apply_config(9'd1,   9'd0,   9'd0,   9'd0);
            4:       apply_config(9'd256, 9'd256, 9'd0,   9'd0);
            default: apply_config(rand_strength(), rand_strength(),
                                  rand_strength(), rand_strength());
        endcase
        case (phase % 4)
            0:       set_idling(0, 0);
            1:       set_idling(63, 0);
            2:       set_idling(0, 63);
            default: set_idling(14, 14);
        endcase
        for (int i = 0; i < PHASE_PIXELS; i++)
            send_pixel(rand_pixel());
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_passthrough();
        test_spare_index();
        test_full_blend();
        test_clamped_registers();
        test_alpha_extremes();
        test_output_hold();
        for (int ph = 0; ph < 10; ph++)
            test_random_phase(ph);

        // Let the pipeline settle so that any stray result shows up
        drain();
        set_idling(0, 0);
        repeat (PIPE_LATENCY + 5) @(posedge i_clk);
        if (pending_blends.size() != 0)
            report_mismatch("results never arrived", 0, pending_blends.size());

        $display("covered %0d pixels over %0d register settings, %0d blends checked",
                 pixels_sent, settings_applied, blends_checked);
        $display("idling: none, sender, receiver, both; one %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (error_count == 0)
            $display("tb_temporal_pixel_blend: clean");
        else
            $display("tb_temporal_pixel_blend: errors");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/tpb_pkg.sv
hw/rtl/tpb_alpha.sv
hw/rtl/tpb_lane.sv
hw/rtl/temporal_pixel_blend.sv
hw/rtl/tpb_checker.sv
sim/tb_temporal_pixel_blend.sv
